### src/abns_pkg.sv
// Package for the ALU with barrel shifter and NZCV flags.
// Holds the operation codes, the flag struct and the shift-kind codes.
// Used by every file of the block by scoped names; depends on nothing.
package abns_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned OpWidth   = 4;

  typedef enum logic [3:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_ADC     = 4'd2,
    OP_SBC     = 4'd3,
    OP_AND     = 4'd4,
    OP_ORR     = 4'd5,
    OP_EOR     = 4'd6,
    OP_NOT     = 4'd7,
    OP_LSL     = 4'd8,
    OP_LSR     = 4'd9,
    OP_ASR     = 4'd10,
    OP_ROR     = 4'd11,
    OP_LSL_SO  = 4'd12,
    OP_LSR_SO  = 4'd13,
    OP_ASR_SO  = 4'd14,
    OP_ROR_SO  = 4'd15
  } abns_op_e;

  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } abns_shift_e;

  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } abns_flags_t;

endpackage

### src/abns_req_if.sv
// Request channel of the ALU: valid/ready handshake and operation payload.
// Depends on abns_pkg for the operand widths.
interface abns_req_if;
  logic                              valid;
  logic                              ready;
  logic [abns_pkg::OpWidth-1:0]      op;
  logic [abns_pkg::DataWidth-1:0]    operand_a;
  logic [abns_pkg::DataWidth-1:0]    operand_b;
  logic                              set_flags;

  modport source (output valid, op, operand_a, operand_b, set_flags, input ready);
  modport sink   (input valid, op, operand_a, operand_b, set_flags, output ready);
endinterface

### src/abns_rsp_if.sv
// Response channel of the ALU: valid/ready handshake, result and flags.
// Depends on abns_pkg for the result width.
interface abns_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [abns_pkg::DataWidth-1:0]    result;
  logic                              flag_n;
  logic                              flag_z;
  logic                              flag_c;
  logic                              flag_v;

  modport source (output valid, result, flag_n, flag_z, flag_c, flag_v, input ready);
  modport sink   (input valid, result, flag_n, flag_z, flag_c, flag_v, output ready);
endinterface

### src/alu_barrel_shifter_nzcv_top.sv
// Top level of the 32-bit ALU with barrel shifter and NZCV flag register.
// Depends on abns_pkg, abns_req_if, abns_rsp_if and abns_exec.
//
// Usage:
//   Requests arrive on req_i (op, operand_a, operand_b, set_flags) and are
//   taken at a clock edge where valid and ready are both high. Each request
//   yields exactly one response on rsp_o carrying the result and the N, Z,
//   C and V flags as they stand after the operation.
//   A request is captured in an input register; the execute logic works on
//   it combinationally and the result register and the flag register are
//   loaded together once the result register is empty or being taken. The
//   response is registered; while rsp_o.ready stays high, one request per
//   cycle is sustained.
//   The flag register is updated as each request leaves the input register,
//   so ADC, SBC and RRX see the carry of the directly preceding request.
//   Reset clears the flag register to zero and empties both registers.
//   When the receiver holds rsp_o.ready low, the response holds and the
//   input register still accepts one more request; after that req_i.ready
//   falls until the response is taken.
module alu_barrel_shifter_nzcv_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  abns_req_if.sink    req_i,
  abns_rsp_if.source  rsp_o
);

  logic                             in_valid_q;
  logic [abns_pkg::OpWidth-1:0]     in_op_q;
  logic [abns_pkg::DataWidth-1:0]   in_a_q;
  logic [abns_pkg::DataWidth-1:0]   in_b_q;
  logic                             in_sf_q;

  logic                             out_valid_q;
  logic [abns_pkg::DataWidth-1:0]   out_result_q;
  abns_pkg::abns_flags_t            out_flags_q;

  abns_pkg::abns_flags_t            flags_q;
  abns_pkg::abns_flags_t            flags_d;
  logic [abns_pkg::DataWidth-1:0]   result_d;

  logic                             advance;
  logic                             exec_fire;
  logic                             req_fire;

  assign advance   = !out_valid_q || rsp_o.ready;
  assign exec_fire = in_valid_q && advance;
  assign req_i.ready = !in_valid_q || advance;
  assign req_fire  = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      in_op_q <= req_i.op;
      in_a_q  <= req_i.operand_a;
      in_b_q  <= req_i.operand_b;
      in_sf_q <= req_i.set_flags;
    end
  end

  abns_exec u_exec (
    .op_i        (in_op_q),
    .operand_a_i (in_a_q),
    .operand_b_i (in_b_q),
    .set_flags_i (in_sf_q),
    .flags_i     (flags_q),
    .result_o    (result_d),
    .flags_o     (flags_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (exec_fire) begin
        flags_q <= flags_d;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      out_result_q <= result_d;
      out_flags_q  <= flags_d;
    end
  end

  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.result = out_result_q;
  assign rsp_o.flag_n = out_flags_q.n;
  assign rsp_o.flag_z = out_flags_q.z;
  assign rsp_o.flag_c = out_flags_q.c;
  assign rsp_o.flag_v = out_flags_q.v;

  a_flags_match_rsp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire |=> (flags_q == out_flags_q))
    else $error("Flag register and response flags disagree.");

  a_hold_stalled_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_a_q) && $stable(in_op_q)))
    else $error("Waiting request in the input register was lost.");

  a_v_only_arith : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_fire && (in_op_q[3] || in_op_q[2] || !in_sf_q)) |=> (flags_q.v == $past(flags_q.v)))
    else $error("Overflow flag changed on a non-arithmetic operation.");

  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> req_i.ready)
    else $error("Request channel stalled with an empty result register.");

endmodule

### src/abns_shifter.sv
// Combinational barrel shifter with immediate-style amount meanings and carry out.
// Depends on abns_pkg for the shift-kind codes and the data width.
module abns_shifter (
  input  abns_pkg::abns_shift_e          kind_i,
  input  logic [abns_pkg::DataWidth-1:0] value_i,
  input  logic [abns_pkg::DataWidth-1:0] amount_i,
  input  logic                           carry_i,
  output logic [abns_pkg::DataWidth-1:0] result_o,
  output logic                           carry_o
);

  logic        amt_zero;
  logic        amt_high;
  logic        amt_is_32;
  logic [4:0]  sh;
  logic [32:0] lsl_wide;
  logic [32:0] lsr_wide;
  logic [32:0] asr_wide;
  logic [63:0] ror_wide;

  assign amt_zero  = (amount_i == 32'd0);
  assign amt_high  = |amount_i[31:5];
  assign amt_is_32 = (amount_i == 32'd32);
  assign sh        = amount_i[4:0];

  assign lsl_wide = {1'b0, value_i} << sh;
  assign lsr_wide = {value_i, 1'b0} >> sh;
  assign asr_wide = 33'($signed({value_i, 1'b0}) >>> sh);
  assign ror_wide = {value_i, value_i} >> sh;

  always_comb begin
    result_o = value_i;
    carry_o  = carry_i;
    case (kind_i)
      abns_pkg::SH_LSL: begin
        if (amt_zero) begin
          result_o = value_i;
          carry_o  = carry_i;
        end else if (!amt_high) begin
          result_o = lsl_wide[31:0];
          carry_o  = lsl_wide[32];
        end else if (amt_is_32) begin
          result_o = '0;
          carry_o  = value_i[0];
        end else begin
          result_o = '0;
          carry_o  = 1'b0;
        end
      end
      abns_pkg::SH_LSR: begin
        if (amt_zero || amt_is_32) begin
          result_o = '0;
          carry_o  = value_i[31];
        end else if (!amt_high) begin
          result_o = lsr_wide[32:1];
          carry_o  = lsr_wide[0];
        end else begin
          result_o = '0;
          carry_o  = 1'b0;
        end
      end
      abns_pkg::SH_ASR: begin
        if (amt_zero || amt_high) begin
          result_o = {32{value_i[31]}};
          carry_o  = value_i[31];
        end else begin
          result_o = asr_wide[32:1];
          carry_o  = asr_wide[0];
        end
      end
      abns_pkg::SH_ROR: begin
        if (amt_zero) begin
          result_o = {carry_i, value_i[31:1]};
          carry_o  = value_i[0];
        end else if (sh == 5'd0) begin
          result_o = value_i;
          carry_o  = value_i[31];
        end else begin
          result_o = ror_wide[31:0];
          carry_o  = ror_wide[31];
        end
      end
      default: begin
        result_o = value_i;
        carry_o  = carry_i;
      end
    endcase
  end

endmodule

### src/abns_exec.sv
// Execute logic: adder, logic unit, shifter selection and the flag update rules.
// Depends on abns_pkg and instantiates abns_shifter.
module abns_exec (
  input  logic [abns_pkg::OpWidth-1:0]   op_i,
  input  logic [abns_pkg::DataWidth-1:0] operand_a_i,
  input  logic [abns_pkg::DataWidth-1:0] operand_b_i,
  input  logic                           set_flags_i,
  input  abns_pkg::abns_flags_t          flags_i,
  output logic [abns_pkg::DataWidth-1:0] result_o,
  output abns_pkg::abns_flags_t          flags_o
);

  abns_pkg::abns_op_e   op;
  logic                 is_sub;
  logic                 carry_in;
  logic [32:0]          sum;
  logic                 add_v;
  logic [31:0]          sh_result;
  logic                 sh_carry;
  logic [31:0]          res;
  logic                 arith;

  assign op = abns_pkg::abns_op_e'(op_i);

  assign is_sub = (op == abns_pkg::OP_SUB) || (op == abns_pkg::OP_SBC);

  always_comb begin
    case (op)
      abns_pkg::OP_ADD: carry_in = 1'b0;
      abns_pkg::OP_SUB: carry_in = 1'b1;
      abns_pkg::OP_ADC: carry_in = flags_i.c;
      abns_pkg::OP_SBC: carry_in = flags_i.c;
      default:          carry_in = 1'b0;
    endcase
  end

  assign sum = {1'b0, operand_a_i} + {1'b0, (is_sub ? ~operand_b_i : operand_b_i)}
             + {32'd0, carry_in};

  assign add_v = is_sub ? (((operand_a_i[31] ^ operand_b_i[31]) & (operand_a_i[31] ^ sum[31])))
                        : ((~(operand_a_i[31] ^ operand_b_i[31])) & (operand_a_i[31] ^ sum[31]));

  abns_shifter u_shifter (
    .kind_i   (abns_pkg::abns_shift_e'(op_i[1:0])),
    .value_i  (operand_a_i),
    .amount_i (operand_b_i),
    .carry_i  (flags_i.c),
    .result_o (sh_result),
    .carry_o  (sh_carry)
  );

  always_comb begin
    arith = 1'b0;
    case (op)
      abns_pkg::OP_ADD,
      abns_pkg::OP_SUB,
      abns_pkg::OP_ADC,
      abns_pkg::OP_SBC: begin
        res   = sum[31:0];
        arith = 1'b1;
      end
      abns_pkg::OP_AND: res = operand_a_i & operand_b_i;
      abns_pkg::OP_ORR: res = operand_a_i | operand_b_i;
      abns_pkg::OP_EOR: res = operand_a_i ^ operand_b_i;
      abns_pkg::OP_NOT: res = ~operand_a_i;
      default:          res = sh_result;
    endcase
  end

  always_comb begin
    flags_o = flags_i;
    if (!op_i[3]) begin
      if (set_flags_i) begin
        flags_o.n = res[31];
        flags_o.z = (res == 32'd0);
        if (arith) begin
          flags_o.c = sum[32];
          flags_o.v = add_v;
        end
      end
    end else if (!op_i[2]) begin
      flags_o.n = res[31];
      flags_o.z = (res == 32'd0);
      flags_o.c = sh_carry;
    end else if (set_flags_i) begin
      flags_o.c = sh_carry;
    end
  end

  assign result_o = res;

endmodule
